[rtl/core/hbs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbs_pkg
// Shared types and constants of the bilinear heightfield sampler.
// ----------------------------------------------------------------------------
package hbs_pkg;
	localparam int unsigned DEF_MAX_COLUMNS = 64;
	localparam int unsigned DEF_MAX_ROWS    = 64;
	localparam int unsigned CFG_IDX_W       = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ORIGIN_X     = 3'd0,
		REG_ORIGIN_Y     = 3'd1,
		REG_CELL_SIZE    = 3'd2,
		REG_INVERSE_CELL = 3'd3,
		REG_COLUMN_COUNT = 3'd4,
		REG_ROW_COUNT    = 3'd5,
		REG_GRID_VALID   = 3'd6
	} cfg_reg_t;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic        operation;
		logic [31:0] pos_x;
		logic [31:0] pos_y;
		logic [5:0]  grid_row;
		logic [5:0]  grid_column;
		logic [31:0] height_value;
	} req_t;

	typedef struct packed {
		logic [31:0] height;
		logic [31:0] slope_x;
		logic [31:0] slope_y;
	} rsp_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0] index;
		logic [31:0]          data;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_POS,
		ST_MUL,
		ST_IDX,
		ST_RD0,
		ST_RD1,
		ST_RD2,
		ST_RD3,
		ST_LX,
		ST_LY,
		ST_NEXT,
		ST_SLOPE,
		ST_SAT,
		ST_OUT
	} state_t;
endpackage

[rtl/core/hbs_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbs_if
// Valid/ready channel carrying a generic payload.
// ----------------------------------------------------------------------------
interface hbs_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

[rtl/core/heightfield_bilinear_sampler.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heightfield_bilinear_sampler
// Height grid in one synchronous RAM; queries return bilinear height and
// central-difference slopes.
// ----------------------------------------------------------------------------
// A write request completes at the edge that accepts it and gives no response,
// so writes can follow each other every cycle while no response is pending. A
// query takes five bilinear samples in turn (center, x+, x-, y+, y-); each
// sample runs through position, multiply and index for each axis, four reads
// of the cell corners through the RAM's single read port, the two
// interpolation steps and one step to advance. Two slope and two saturation
// steps and the output step follow, after which the response is valid; with
// the grid not valid the query goes straight to the output step. The next
// request is taken once the response has been accepted downstream.
module heightfield_bilinear_sampler
	import hbs_pkg::*;
#(
	parameter int unsigned MAX_COLUMNS = DEF_MAX_COLUMNS,
	parameter int unsigned MAX_ROWS    = DEF_MAX_ROWS
) (
	input logic clk,
	input logic arst_n,
	hbs_if.sink   req,
	hbs_if.source rsp,
	hbs_if.sink   cfg
);
	localparam int unsigned CW = $clog2(MAX_COLUMNS);
	localparam int unsigned RW = $clog2(MAX_ROWS);
	localparam int unsigned AW = CW + RW;

	// configuration
	logic signed [31:0] origin_x_q, origin_y_q;
	logic [30:0] cell_size_q, inverse_cell_q;
	logic [6:0]  column_count_q, row_count_q;
	logic        grid_valid_q;

	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			cell_size_q <= 31'd65536;
			inverse_cell_q <= 31'd65536;
			column_count_q <= 7'd2;
			row_count_q <= 7'd2;
			grid_valid_q <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg.payload.index)
				REG_ORIGIN_X:     origin_x_q <= cfg.payload.data;
				REG_ORIGIN_Y:     origin_y_q <= cfg.payload.data;
				REG_CELL_SIZE:    cell_size_q <= cfg.payload.data[30:0];
				REG_INVERSE_CELL: inverse_cell_q <= cfg.payload.data[30:0];
				REG_COLUMN_COUNT: column_count_q <= cfg.payload.data[6:0];
				REG_ROW_COUNT:    row_count_q <= cfg.payload.data[6:0];
				REG_GRID_VALID:   grid_valid_q <= cfg.payload.data[0];
				default: ;
			endcase
		end
	end

	// effective counts, clamped to [2, max]
	logic [10:0] ncol, nrow;
	always_comb begin
		ncol = {4'd0, column_count_q};
		nrow = {4'd0, row_count_q};
		if (ncol < 11'd2) ncol = 11'd2;
		if (ncol > 11'(MAX_COLUMNS)) ncol = 11'(MAX_COLUMNS);
		if (nrow < 11'd2) nrow = 11'd2;
		if (nrow > 11'(MAX_ROWS)) nrow = 11'(MAX_ROWS);
	end

	// height RAM
	logic [31:0] mem [MAX_ROWS*MAX_COLUMNS];
	logic          mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [31:0]   mem_wdata, mem_rdata_q;
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		mem_rdata_q <= mem[mem_raddr];
	end

	state_t state_q, state_d;
	req_t   req_q;
	logic [2:0]  samp_q;        // 0 center, 1 x+, 2 x-, 3 y+, 4 y-
	logic        axis_q;        // 0 x, 1 y
	logic signed [33:0] d_q;
	logic [63:0] prod_q;
	logic [CW-1:0] ix_q;
	logic [RW-1:0] iy_q;
	logic [16:0] fx_q, fy_q;
	logic signed [31:0] c00_q, c01_q, c10_q;
	logic signed [32:0] lo_q;
	logic signed [32:0] samp_v_q [5];
	logic signed [32:0] sdiff_q;
	logic signed [31:0] sx_q;
	rsp_t   out_q;
	logic   out_v_q;

	// sample position along current axis, full width
	logic signed [33:0] c_ext, pos_sel, org_sel;
	always_comb begin
		c_ext = {3'd0, cell_size_q};
		if (axis_q == 1'b0) begin
			pos_sel = 34'(signed'(req_q.pos_x));
			org_sel = 34'(origin_x_q);
			if (samp_q == 3'd1) pos_sel = pos_sel + c_ext;
			if (samp_q == 3'd2) pos_sel = pos_sel - c_ext;
		end else begin
			pos_sel = 34'(signed'(req_q.pos_y));
			org_sel = 34'(origin_y_q);
			if (samp_q == 3'd3) pos_sel = pos_sel + c_ext;
			if (samp_q == 3'd4) pos_sel = pos_sel - c_ext;
		end
	end

	// d*inv, d < 2^33: low 32 bits of d times inv, plus inv<<32 when bit 32 is set
	logic [31:0] mul_a;
	logic [62:0] mul_p;
	assign mul_a = d_q[31:0];
	assign mul_p = mul_a * inverse_cell_q;

	// index/fraction from product
	logic [63:0] q_full;
	logic [10:0] cnt;
	logic        clamp;
	assign q_full = prod_q;
	assign cnt = axis_q ? nrow : ncol;
	assign clamp = (q_full[63:32] >= {21'd0, cnt - 11'd1});

	// lerp: a + trunc((b-a)*f/65536)
	logic signed [33:0] la, lb, ldiff;
	logic [16:0]        lf;
	logic signed [51:0] lprod;
	logic signed [51:0] lq;
	always_comb begin
		if (state_q == ST_LY) begin
			la = 34'(lo_q);
			lb = 34'(signed'(c10_q)) ;
			lf = fy_q;
		end else if (state_q == ST_LX) begin
			// upper row: right corner straight from the RAM
			la = 34'(c00_q);
			lb = 34'(signed'(mem_rdata_q));
			lf = fx_q;
		end else begin
			la = 34'(c00_q);
			lb = 34'(c01_q);
			lf = fx_q;
		end
		ldiff = lb - la;
		lprod = 52'(ldiff) * $signed({1'b0, lf});
		lq = (lprod < 0) ? -((-lprod) >>> 16) : (lprod >>> 16);
	end

	logic signed [33:0] lres;
	assign lres = la + 34'(lq);

	// slope
	logic signed [64:0] sprod;
	logic signed [64:0] sq;
	assign sprod = 65'(sdiff_q) * $signed({1'b0, inverse_cell_q});
	assign sq = (sprod < 0) ? -((-sprod) >>> 17) : (sprod >>> 17);
	logic signed [31:0] ssat;
	assign ssat = (sq > 65'sd2147483647) ? 32'sh7fffffff :
		(sq < -65'sd2147483648) ? 32'sh80000000 : sq[31:0];

	logic [CW-1:0] ix_n;
	logic [RW-1:0] iy_n;
	assign ix_n = ix_q + CW'(1);
	assign iy_n = iy_q + RW'(1);

	logic req_fire;
	assign req_fire = req.valid && req.ready;

	always_comb begin
		state_d = state_q;
		req.ready = (state_q == ST_IDLE) && !out_v_q;
		mem_we = 1'b0;
		mem_waddr = {RW'(req.payload.grid_row), CW'(req.payload.grid_column)};
		mem_wdata = req.payload.height_value;
		mem_raddr = {iy_q, ix_q};
		unique case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					if (req.payload.operation == OP_WRITE) begin
						mem_we = (32'(req.payload.grid_row) < MAX_ROWS) &&
							(32'(req.payload.grid_column) < MAX_COLUMNS);
					end else if (!grid_valid_q) begin
						state_d = ST_OUT;
					end else begin
						state_d = ST_POS;
					end
				end
			end
			ST_POS:   state_d = ST_MUL;
			ST_MUL:   state_d = ST_IDX;
			ST_IDX:   state_d = axis_q ? ST_RD0 : ST_POS;
			ST_RD0:   state_d = ST_RD1;
			ST_RD1: begin mem_raddr = {iy_q, ix_n}; state_d = ST_RD2; end
			ST_RD2: begin mem_raddr = {iy_n, ix_q}; state_d = ST_RD3; end
			ST_RD3: begin mem_raddr = {iy_n, ix_n}; state_d = ST_LX; end
			ST_LX:    state_d = ST_LY;
			ST_LY:    state_d = ST_NEXT;
			ST_NEXT:  state_d = (samp_q == 3'd4) ? ST_SLOPE : ST_POS;
			ST_SLOPE: state_d = ST_SAT;
			ST_SAT:   state_d = axis_q ? ST_OUT : ST_SLOPE;
			ST_OUT:   state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_v_q <= 1'b0;
			samp_q <= '0;
			axis_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (rsp.valid && rsp.ready) out_v_q <= 1'b0;
			if (state_q == ST_IDLE && req_fire) begin
				samp_q <= '0;
				axis_q <= 1'b0;
			end
			if (state_q == ST_IDX) axis_q <= ~axis_q;
			if (state_q == ST_NEXT) begin
				axis_q <= 1'b0;
				if (samp_q != 3'd4) samp_q <= samp_q + 3'd1;
			end
			if (state_q == ST_SAT) axis_q <= ~axis_q;
			if (state_q == ST_OUT) out_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req_fire) req_q <= req.payload;
		unique case (state_q)
			ST_POS: d_q <= pos_sel - org_sel;
			ST_MUL: begin
				// high part contributes only when d >= 2^32
				prod_q <= {1'b0, mul_p} + ({64{d_q[32]}} & ({33'd0, inverse_cell_q} << 32));
			end
			ST_IDX: begin
				if (d_q < 0 || inverse_cell_q == '0) begin
					if (axis_q) begin iy_q <= '0; fy_q <= '0; end
					else begin ix_q <= '0; fx_q <= '0; end
				end else if (clamp) begin
					if (axis_q) begin iy_q <= RW'(nrow - 11'd2); fy_q <= 17'h10000; end
					else begin ix_q <= CW'(ncol - 11'd2); fx_q <= 17'h10000; end
				end else begin
					if (axis_q) begin iy_q <= RW'(q_full[42:32]); fy_q <= {1'b0, q_full[31:16]}; end
					else begin ix_q <= CW'(q_full[42:32]); fx_q <= {1'b0, q_full[31:16]}; end
				end
			end
			ST_RD1: c00_q <= mem_rdata_q;
			ST_RD2: c01_q <= mem_rdata_q;
			ST_RD3: begin
				// lower row result, then keep the upper-left corner
				lo_q <= lres[32:0];
				c00_q <= mem_rdata_q;
			end
			ST_LX: begin
				c01_q <= mem_rdata_q;
			end
			default: ;
		endcase
		// upper row lerp runs in ST_LX through the shared lerp
		if (state_q == ST_LX) c10_q <= lres[31:0];
		if (state_q == ST_LY) samp_v_q[samp_q] <= lres[32:0];
		if (state_q == ST_SLOPE)
			sdiff_q <= axis_q ? samp_v_q[3] - samp_v_q[4]
				: samp_v_q[1] - samp_v_q[2];
		if (state_q == ST_SAT && !axis_q) sx_q <= (inverse_cell_q == '0) ? '0 : ssat;
		if (state_q == ST_OUT) begin
			if (grid_valid_q && samp_q == 3'd4) begin
				out_q.height  <= samp_v_q[0][31:0];
				out_q.slope_x <= sx_q;
				out_q.slope_y <= (inverse_cell_q == '0) ? '0 : ssat;
			end else begin
				out_q <= '0;
			end
		end
	end

	assign rsp.valid = out_v_q;
	assign rsp.payload = out_q;

	a_write_no_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		(req_fire && req.payload.operation == OP_WRITE) |=> !out_v_q)
		else $error("write produced a response");
	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !req.ready)
		else $error("request taken while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !rsp.ready) |=> (out_v_q && $stable(out_q)))
		else $error("response dropped");
endmodule
